FILE: hw/rtl/ssc_pkg.sv
// Shared types, constants, calibration tables and helper functions for the
// servo segment clock sequencer. No dependencies.
package ssc_pkg;

  localparam int CHANNELS_PER_BANK = 16;
  localparam int BANKS             = 2;
  localparam int CH_W              = $clog2(CHANNELS_PER_BANK);
  localparam int PULSE_W           = 12;
  localparam int DIGITS            = 10;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 12;

  localparam logic [PULSE_W-1:0] PULSE_MAX      = 12'hFFF;
  localparam logic [4:0]         HALF_DAY_HOURS = 5'd12;
  localparam logic [CH_W-1:0]    SLEEP_LAST_CH  = 4'd14;
  localparam logic [2:0]         SEG_LAST_SIDE  = 3'd5;

  // Segment numbers inside one digit.
  localparam logic [2:0] SEG_B = 3'd1;
  localparam logic [2:0] SEG_F = 3'd5;
  localparam logic [2:0] SEG_G = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLEAR_OFFSET = 3'd0,
    CFG_SLEEP_FIRST  = 3'd1,
    CFG_SLEEP_LAST   = 3'd2,
    CFG_SV_HOUR      = 3'd3,
    CFG_SV_FIRST     = 3'd4,
    CFG_SV_LAST      = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_PLAIN   = 2'd0,
    OP_ADD_SAT = 2'd1,
    OP_SUB_SAT = 2'd2
  } pulse_op_e;

  typedef struct packed {
    logic [PULSE_W-1:0] clear_offset;
    logic [4:0]         sleep_first;
    logic [4:0]         sleep_last;
    logic [4:0]         sv_hour;
    logic [5:0]         sv_first;
    logic [5:0]         sv_last;
  } cfg_t;

  typedef struct packed {
    logic            emit;
    logic            last;
    logic            bank;
    logic [CH_W-1:0] channel;
    logic            lit;
    pulse_op_e       op;
  } step_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  localparam logic [PULSE_W-1:0] POS_OFF [BANKS][CHANNELS_PER_BANK] = '{
    '{12'd460, 12'd445, 12'd445, 12'd444, 12'd445, 12'd460, 12'd460, 12'd0,
      12'd445, 12'd455, 12'd455, 12'd440, 12'd460, 12'd445, 12'd445, 12'd0},
    '{12'd450, 12'd455, 12'd435, 12'd460, 12'd445, 12'd455, 12'd435, 12'd0,
      12'd440, 12'd460, 12'd430, 12'd440, 12'd465, 12'd445, 12'd435, 12'd0}
  };

  localparam logic [PULSE_W-1:0] POS_ON [BANKS][CHANNELS_PER_BANK] = '{
    '{12'd266, 12'd255, 12'd250, 12'd245, 12'd260, 12'd266, 12'd271, 12'd0,
      12'd250, 12'd265, 12'd260, 12'd250, 12'd280, 12'd250, 12'd260, 12'd0},
    '{12'd252, 12'd263, 12'd252, 12'd279, 12'd248, 12'd260, 12'd243, 12'd0,
      12'd253, 12'd280, 12'd245, 12'd245, 12'd282, 12'd260, 12'd240, 12'd0}
  };

  // Bit s set means segment s is lit.
  localparam logic [6:0] SEG_MASK [DIGITS] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // A digit above nine shows nothing; segment seven does not exist.
  function automatic logic seg_lit(input logic [3:0] digit, input logic [2:0] s);
    logic res;
    res = 1'b0;
    if ((digit <= 4'd9) && (s <= SEG_G)) begin
      res = SEG_MASK[digit][s];
    end
    return res;
  endfunction

  // Split a 6-bit value into decimal digits: multiply by 205/2048 is exact
  // for every value below 64.
  function automatic digits_t split10(input logic [5:0] v);
    logic [13:0] prod;
    logic [2:0]  tens;
    logic [5:0]  tens_x10;
    digits_t     res;
    prod     = {8'd0, v} * 14'd205;
    tens     = prod[13:11];
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    res.tens  = {1'b0, tens};
    res.units = 4'(v - tens_x10);
    return res;
  endfunction

endpackage

FILE: hw/rtl/ssc_time_if.sv
// Request channel carrying one time reading (hour, minute, second).
// Depends on nothing.
interface ssc_time_if;
  logic       valid;
  logic       ready;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;

  modport source (output valid, output hours, output minutes, output seconds,
                  input ready);
  modport sink   (input valid, input hours, input minutes, input seconds,
                  output ready);
endinterface

FILE: hw/rtl/ssc_write_if.sv
// Request channel carrying one servo pulse write.
// Depends on nothing.
interface ssc_write_if;
  logic        valid;
  logic        ready;
  logic        bank;
  logic [3:0]  channel;
  logic [11:0] pulse_off;
  logic        last;

  modport source (output valid, output bank, output channel, output pulse_off,
                  output last, input ready);
  modport sink   (input valid, input bank, input channel, input pulse_off,
                  input last, output ready);
endinterface

FILE: hw/rtl/servo_segment_clock_sequencer.sv
// Top level of the servo segment clock sequencer: configuration registers,
// output register and the sequencer and pulse unit. Depends on ssc_pkg,
// ssc_time_if, ssc_write_if, ssc_sequencer and ssc_pulse_unit.
//
// Usage. A time reading (hours, minutes, seconds) arrives as a request on
// req_i. For every reading the block sends an ordered run of servo pulse
// writes on wr_o, one request per write; the final write of a run carries
// last. Bank 0 drives the hour digits and bank 1 the minute digits.
// In the cycle after acceptance the reading is split into digits, then
// the sequencer walks one plan slot per cycle. A normal reading walks 36
// slots (twelve for the middle segments, of which the push-aside slots still
// occupy the walk but send no write when not needed, then 24 side segments);
// a sleep hour walks 30.
// The first write reaches wr_o through the output register once the digits
// are split and the first slot that sends a write has been walked. req_i.ready
// is high only while no reading is in progress.
// When the receiver stalls, the finished write waits in the output register
// and the slot walk halts until it is taken; nothing is dropped.
// Reset restores the configuration defaults and clears the remembered
// digits to zero. Configuration must only be written while the block is idle.
module servo_segment_clock_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ssc_time_if.sink                           req_i,
  ssc_write_if.source                        wr_o,
  input  logic                               cfg_we_i,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  ssc_pkg::cfg_t  cfg_q, cfg_d;
  ssc_pkg::step_t step;
  logic           adv;
  logic [ssc_pkg::PULSE_W-1:0] pulse;

  logic                        out_valid_q, out_valid_d;
  logic                        out_bank_q;
  logic [ssc_pkg::CH_W-1:0]    out_channel_q;
  logic [ssc_pkg::PULSE_W-1:0] out_pulse_q;
  logic                        out_last_q;

  // Configuration decode. Unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssc_pkg::CFG_CLEAR_OFFSET: cfg_d.clear_offset = cfg_data_i;
        ssc_pkg::CFG_SLEEP_FIRST:  cfg_d.sleep_first  = cfg_data_i[4:0];
        ssc_pkg::CFG_SLEEP_LAST:   cfg_d.sleep_last   = cfg_data_i[4:0];
        ssc_pkg::CFG_SV_HOUR:      cfg_d.sv_hour      = cfg_data_i[4:0];
        ssc_pkg::CFG_SV_FIRST:     cfg_d.sv_first     = cfg_data_i[5:0];
        ssc_pkg::CFG_SV_LAST:      cfg_d.sv_last      = cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clear_offset <= 12'd100;
      cfg_q.sleep_first  <= 5'd7;
      cfg_q.sleep_last   <= 5'd18;
      cfg_q.sv_hour      <= 5'd23;
      cfg_q.sv_first     <= 6'd58;
      cfg_q.sv_last      <= 6'd59;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The slot walk moves whenever the output register is free or being taken.
  assign adv = !out_valid_q || wr_o.ready;

  ssc_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .adv_i  (adv),
    .step_o (step)
  );

  ssc_pulse_unit u_pulse (
    .step_i   (step),
    .offset_i (cfg_q.clear_offset),
    .pulse_o  (pulse)
  );

  // Output register: holds the current write until the receiver takes it.
  assign out_valid_d = adv ? step.emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && step.emit) begin
      out_bank_q    <= step.bank;
      out_channel_q <= step.channel;
      out_pulse_q   <= pulse;
      out_last_q    <= step.last;
    end
  end

  assign wr_o.valid     = out_valid_q;
  assign wr_o.bank      = out_bank_q;
  assign wr_o.channel   = out_channel_q;
  assign wr_o.pulse_off = out_pulse_q;
  assign wr_o.last      = out_last_q;

  // Once the final write of a run is loaded, a new reading can be taken.
  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step.emit && step.last |=> req_i.ready)
    else $error("sequencer did not return to idle after the final write");

  // The digit split cycle after acceptance never produces a write.
  a_split_cycle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !step.emit && !req_i.ready)
    else $error("write produced during digit split or input still ready");

  // Channel 15 carries no servo and is never written.
  a_unused_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.emit |-> step.channel != 4'd15)
    else $error("write to an unused channel");

  // No write is produced while the block is idle.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !step.emit)
    else $error("write produced while idle");

endmodule

FILE: hw/rtl/ssc_pulse_unit.sv
// Shared pulse arithmetic: calibration lookup and one saturating add/subtract.
// Depends on ssc_pkg.
module ssc_pulse_unit (
  input  ssc_pkg::step_t                step_i,
  input  logic [ssc_pkg::PULSE_W-1:0]   offset_i,
  output logic [ssc_pkg::PULSE_W-1:0]   pulse_o
);

  logic [ssc_pkg::PULSE_W-1:0] base;
  logic [ssc_pkg::PULSE_W:0]   operand;
  logic [ssc_pkg::PULSE_W:0]   res;
  logic                        is_sub;

  assign base = step_i.lit ? ssc_pkg::POS_ON[step_i.bank][step_i.channel]
                           : ssc_pkg::POS_OFF[step_i.bank][step_i.channel];

  // One adder serves both directions; subtraction adds the complement.
  assign is_sub  = (step_i.op == ssc_pkg::OP_SUB_SAT);
  assign operand = is_sub ? ~{1'b0, offset_i} : {1'b0, offset_i};
  assign res     = {1'b0, base} + operand + {{ssc_pkg::PULSE_W{1'b0}}, is_sub};

  always_comb begin
    case (step_i.op)
      ssc_pkg::OP_ADD_SAT: pulse_o = res[ssc_pkg::PULSE_W] ? ssc_pkg::PULSE_MAX
                                                           : res[ssc_pkg::PULSE_W-1:0];
      ssc_pkg::OP_SUB_SAT: pulse_o = res[ssc_pkg::PULSE_W] ? '0
                                                           : res[ssc_pkg::PULSE_W-1:0];
      default:             pulse_o = base;
    endcase
  end

endmodule

FILE: hw/rtl/ssc_sequencer.sv
// Sequencer: captures a time reading, splits it into digits and walks the
// write plan one slot per step. Depends on ssc_pkg and ssc_time_if.
module ssc_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  ssc_time_if.sink            req_i,
  input  ssc_pkg::cfg_t       cfg_i,
  input  logic                adv_i,
  output ssc_pkg::step_t      step_o
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_DIGITS  = 5'b00010,
    PH_MIDDLE  = 5'b00100,
    PH_SEGMENT = 5'b01000,
    PH_SLEEP   = 5'b10000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [4:0] hours_q;
  logic [5:0] minutes_q, seconds_q;
  // Digit order: minute tens, minute units, hour tens, hour units.
  logic [3:0] cur_q [4];
  logic [3:0] cur_d [4];
  logic [3:0] prev_q [4];
  logic [3:0] prev_d [4];
  logic [1:0] dig_q, dig_d;
  logic [1:0] sub_q, sub_d;
  logic [3:0] idx_q, idx_d;
  logic       bank_q, bank_d;

  logic             accept;
  logic             view_sec, asleep;
  logic [4:0]       h_red, h12;
  logic             h_tens;
  logic [4:0]       h_units;
  ssc_pkg::digits_t min_digits;
  logic [1:0]       rd_sel;
  logic [3:0]       d_now, d_prev;
  logic             mid_differs;
  logic             done;

  assign req_i.ready = (phase_q == PH_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Digit decode from the captured reading.
  assign view_sec = (hours_q == cfg_i.sv_hour) && (minutes_q >= cfg_i.sv_first) &&
                    (minutes_q <= cfg_i.sv_last);
  assign asleep   = (hours_q >= cfg_i.sleep_first) && (hours_q <= cfg_i.sleep_last);
  assign h_red    = (hours_q > ssc_pkg::HALF_DAY_HOURS) ?
                    hours_q - ssc_pkg::HALF_DAY_HOURS : hours_q;
  assign h12      = (h_red == 5'd0) ? ssc_pkg::HALF_DAY_HOURS : h_red;
  assign h_tens   = (h12 >= 5'd10);
  assign h_units  = h_tens ? h12 - 5'd10 : h12;
  assign min_digits = ssc_pkg::split10(view_sec ? seconds_q : minutes_q);

  // The segment phase walks hour tens, hour units, minute tens, minute units.
  assign rd_sel      = (phase_q == PH_MIDDLE) ? dig_q : {~dig_q[1], dig_q[0]};
  assign d_now       = cur_q[rd_sel];
  assign d_prev      = prev_q[rd_sel];
  assign mid_differs = ssc_pkg::seg_lit(d_now, ssc_pkg::SEG_G) !=
                       ssc_pkg::seg_lit(d_prev, ssc_pkg::SEG_G);

  always_comb begin
    step_o = '{emit: 1'b0, last: 1'b0, bank: 1'b0, channel: '0, lit: 1'b0,
               op: ssc_pkg::OP_PLAIN};
    unique case (phase_q)
      PH_MIDDLE: begin
        step_o.bank = ~dig_q[1];
        case (sub_q)
          2'd0: begin
            step_o.emit    = mid_differs && ssc_pkg::seg_lit(d_prev, ssc_pkg::SEG_B);
            step_o.channel = {dig_q[0], ssc_pkg::SEG_B};
            step_o.lit     = 1'b1;
            step_o.op      = ssc_pkg::OP_ADD_SAT;
          end
          2'd1: begin
            step_o.emit    = mid_differs && ssc_pkg::seg_lit(d_prev, ssc_pkg::SEG_G);
            step_o.channel = {dig_q[0], ssc_pkg::SEG_F};
            step_o.op      = ssc_pkg::OP_SUB_SAT;
          end
          default: begin
            step_o.emit    = 1'b1;
            step_o.channel = {dig_q[0], ssc_pkg::SEG_G};
            step_o.lit     = ssc_pkg::seg_lit(d_now, ssc_pkg::SEG_G);
          end
        endcase
      end
      PH_SEGMENT: begin
        step_o.emit    = 1'b1;
        step_o.bank    = dig_q[1];
        step_o.channel = {dig_q[0], idx_q[2:0]};
        step_o.lit     = ssc_pkg::seg_lit(d_now, idx_q[2:0]);
        step_o.last    = (dig_q == 2'd3) && (idx_q[2:0] == ssc_pkg::SEG_LAST_SIDE);
      end
      PH_SLEEP: begin
        step_o.emit    = 1'b1;
        step_o.bank    = bank_q;
        step_o.channel = idx_q;
        step_o.last    = bank_q && (idx_q == ssc_pkg::SLEEP_LAST_CH);
      end
      default: ;
    endcase
  end

  assign done = adv_i && step_o.last;

  always_comb begin
    phase_d = phase_q;
    dig_d   = dig_q;
    sub_d   = sub_q;
    idx_d   = idx_q;
    bank_d  = bank_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (accept) begin
          phase_d = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        cur_d[0] = min_digits.tens;
        cur_d[1] = min_digits.units;
        cur_d[2] = {3'd0, h_tens};
        cur_d[3] = h_units[3:0];
        dig_d    = 2'd0;
        sub_d    = 2'd0;
        idx_d    = 4'd0;
        bank_d   = 1'b0;
        phase_d  = asleep ? PH_SLEEP : PH_MIDDLE;
      end
      PH_MIDDLE: begin
        if (adv_i) begin
          if (sub_q == 2'd2) begin
            sub_d = 2'd0;
            dig_d = dig_q + 2'd1;
            if (dig_q == 2'd3) begin
              phase_d = PH_SEGMENT;
              idx_d   = 4'd0;
            end
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end
      PH_SEGMENT: begin
        if (adv_i) begin
          dig_d = dig_q + 2'd1;
          if (dig_q == 2'd3) begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      PH_SLEEP: begin
        if (adv_i) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == ssc_pkg::SLEEP_LAST_CH) begin
            idx_d  = 4'd0;
            bank_d = 1'b1;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
    if (done) begin
      phase_d = PH_IDLE;
      prev_d  = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dig_q   <= 2'd0;
      sub_q   <= 2'd0;
      idx_q   <= 4'd0;
      bank_q  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prev_q[i] <= 4'd0;
        cur_q[i]  <= 4'd0;
      end
    end else begin
      phase_q <= phase_d;
      dig_q   <= dig_d;
      sub_q   <= sub_d;
      idx_q   <= idx_d;
      bank_q  <= bank_d;
      prev_q  <= prev_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hours_q   <= req_i.hours;
      minutes_q <= req_i.minutes;
      seconds_q <= req_i.seconds;
    end
  end

endmodule

FILE: tb/servo_segment_clock_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for servo_segment_clock_sequencer: directed and random
// time readings, checked write by write against a built-in predictor.
// Depends on ssc_pkg, ssc_time_if, ssc_write_if and the sequencer RTL.
module servo_segment_clock_sequencer_tb;
  import ssc_pkg::*;

  // A directed pass at the reset configuration comes first. After it, eight
  // phases of random readings follow, each under a configuration of its own.
  // The configuration is only rewritten once every predicted write has come back.
  localparam int DIRECTED_ROWS   = 23;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES   = 40;
  localparam int REPORT_LIMIT    = 10;

  // Segment numbers within one digit. The middle bar is the one whose change
  // makes the sequencer push its upper neighbours aside first.
  localparam int UPPER_RIGHT_SEG = 1;
  localparam int UPPER_LEFT_SEG  = 5;
  localparam int MIDDLE_SEG      = 6;
  localparam int SIDE_SEGS       = 6;
  localparam int SLEEP_CHANNELS  = 15;

  // Calibration of every servo, in the rest (segment hidden) and lit positions.
  localparam logic [11:0] REST_PULSE [2][16] = '{
    '{12'd460, 12'd445, 12'd445, 12'd444, 12'd445, 12'd460, 12'd460, 12'd0,
      12'd445, 12'd455, 12'd455, 12'd440, 12'd460, 12'd445, 12'd445, 12'd0},
    '{12'd450, 12'd455, 12'd435, 12'd460, 12'd445, 12'd455, 12'd435, 12'd0,
      12'd440, 12'd460, 12'd430, 12'd440, 12'd465, 12'd445, 12'd435, 12'd0}
  };
  localparam logic [11:0] LIT_PULSE [2][16] = '{
    '{12'd266, 12'd255, 12'd250, 12'd245, 12'd260, 12'd266, 12'd271, 12'd0,
      12'd250, 12'd265, 12'd260, 12'd250, 12'd280, 12'd250, 12'd260, 12'd0},
    '{12'd252, 12'd263, 12'd252, 12'd279, 12'd248, 12'd260, 12'd243, 12'd0,
      12'd253, 12'd280, 12'd245, 12'd245, 12'd282, 12'd260, 12'd240, 12'd0}
  };
  // Bit s set means segment s of that decimal digit is lit.
  localparam logic [6:0] SEGMENTS_OF [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] writes;   // typed run length, zero where the predictor decides
  } reading_row_t;

  typedef struct packed {
    logic              bank;
    logic [CH_W-1:0]   channel;
    logic [PULSE_W-1:0] pulse_off;
    logic              last;
  } servo_write_t;

  // The directed readings. The run length is typed in only where it is obvious.
  // Right after reset all remembered digits are zero, so 00:00:00 moves only the
  // hour-units middle bar (digit 2), with one push-aside: 5 middle writes plus
  // 24 side writes. Every sleep hour gives 15 writes per bank.
  localparam reading_row_t READINGS [DIRECTED_ROWS] = '{
    '{5'd0,  6'd0,  6'd0,  6'd29},  // first reading after reset
    '{5'd7,  6'd0,  6'd0,  6'd30},  // first sleep hour
    '{5'd18, 6'd59, 6'd59, 6'd30},  // last sleep hour
    '{5'd6,  6'd59, 6'd59, 6'd0},   // just before the sleep span
    '{5'd19, 6'd0,  6'd0,  6'd0},   // just after it
    '{5'd23, 6'd58, 6'd7,  6'd0},   // seconds view, first minute
    '{5'd23, 6'd59, 6'd59, 6'd0},   // seconds view, last minute
    '{5'd23, 6'd57, 6'd33, 6'd0},   // one minute early for the seconds view
    '{5'd23, 6'd0,  6'd48, 6'd0},
    '{5'd31, 6'd63, 6'd63, 6'd0},   // every field at its widest
    '{5'd24, 6'd60, 6'd61, 6'd0},   // hour, minute and second past their range
    '{5'd0,  6'd38, 6'd0,  6'd0},
    '{5'd1,  6'd22, 6'd0,  6'd0},
    '{5'd2,  6'd44, 6'd0,  6'd0},
    '{5'd3,  6'd10, 6'd9,  6'd0},
    '{5'd4,  6'd55, 6'd0,  6'd0},
    '{5'd5,  6'd16, 6'd0,  6'd0},
    '{5'd20, 6'd27, 6'd0,  6'd0},
    '{5'd21, 6'd38, 6'd0,  6'd0},
    '{5'd22, 6'd49, 6'd0,  6'd0},
    '{5'd12, 6'd0,  6'd0,  6'd30},  // noon sleeps at the reset span
    '{5'd16, 6'd31, 6'd17, 6'd30},
    '{5'd0,  6'd0,  6'd0,  6'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ssc_time_if  time_req ();
  ssc_write_if servo_wr ();

  servo_segment_clock_sequencer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (time_req),
    .wr_o       (servo_wr),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the configuration and of the digits last shown.
  logic [11:0] clear_offset;
  logic [4:0]  sleep_first;
  logic [4:0]  sleep_last;
  logic [4:0]  sv_hour;
  logic [5:0]  sv_first;
  logic [5:0]  sv_last;
  logic [3:0]  shown_minute_tens;
  logic [3:0]  shown_minute_units;
  logic [3:0]  shown_hour_tens;
  logic [3:0]  shown_hour_units;

  servo_write_t expected_writes [$];
  int           run_lengths [$];     // typed run length per accepted request, or 0
  int           writes_in_run;
  int           mismatches;
  int           gap_pct;
  int           stall_pct;

  // Running wall clock for the random part, so that most readings move the
  // digits the way a real clock does.
  int wall_h;
  int wall_m;
  int wall_s;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run: several times the slowest legal run.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic segment_on(input logic [3:0] digit, input int s);
    if (digit > 4'd9) return 1'b0;
    return SEGMENTS_OF[digit][s];
  endfunction

  function automatic logic [11:0] servo_position(input logic bank, input logic [3:0] ch,
                                                 input logic lit);
    return lit ? LIT_PULSE[bank][ch] : REST_PULSE[bank][ch];
  endfunction

  task automatic push_write(input logic bank, input logic [3:0] ch, input logic [11:0] pulse);
    servo_write_t w;
    w.bank      = bank;
    w.channel   = ch;
    w.pulse_off = pulse;
    w.last      = 1'b0;
    expected_writes.push_back(w);
  endtask

  // Middle bar of one digit, preceded by the push-aside writes when it changes.
  task automatic predict_middle(input logic bank, input logic [3:0] base,
                                input logic [3:0] now, input logic [3:0] was);
    int          pushed;
    logic [11:0] rest;
    if (segment_on(now, MIDDLE_SEG) != segment_on(was, MIDDLE_SEG)) begin
      if (segment_on(was, UPPER_RIGHT_SEG)) begin
        pushed = int'(LIT_PULSE[bank][base + 4'd1]) + int'(clear_offset);
        push_write(bank, base + 4'd1, (pushed > 4095) ? 12'd4095 : 12'(pushed));
      end
      if (segment_on(was, MIDDLE_SEG)) begin
        rest = REST_PULSE[bank][base + 4'd5];
        push_write(bank, base + 4'd5, (rest > clear_offset) ? rest - clear_offset : 12'd0);
      end
    end
    push_write(bank, base + 4'd6, servo_position(bank, base + 4'd6, segment_on(now, MIDDLE_SEG)));
  endtask

  // Appends the whole run of writes that one time reading causes.
  task automatic predict_readout(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
    logic [4:0]   h12;
    logic [5:0]   shown;
    logic [3:0]   ht, hu, mt, mu;
    logic         show_seconds, asleep;
    servo_write_t tail;
    show_seconds = (h == sv_hour) && (m >= sv_first) && (m <= sv_last);
    asleep       = (h >= sleep_first) && (h <= sleep_last);
    h12 = h;
    if (h12 > 5'd12) h12 = h12 - 5'd12;
    if (h12 == 5'd0) h12 = 5'd12;
    ht = 4'(h12 / 10);
    hu = 4'(h12 % 10);
    shown = show_seconds ? s : m;
    mt = 4'(shown / 10);
    mu = 4'(shown % 10);
    if (asleep) begin
      for (int b = 0; b < 2; b++) begin
        for (int ch = 0; ch < SLEEP_CHANNELS; ch++) begin
          push_write(b[0], 4'(ch), REST_PULSE[b][ch]);
        end
      end
    end else begin
      predict_middle(1'b1, 4'd0, mt, shown_minute_tens);
      predict_middle(1'b1, 4'd8, mu, shown_minute_units);
      predict_middle(1'b0, 4'd0, ht, shown_hour_tens);
      predict_middle(1'b0, 4'd8, hu, shown_hour_units);
      for (int i = 0; i < SIDE_SEGS; i++) begin
        push_write(1'b0, 4'(i),     servo_position(1'b0, 4'(i),     segment_on(ht, i)));
        push_write(1'b0, 4'(i + 8), servo_position(1'b0, 4'(i + 8), segment_on(hu, i)));
        push_write(1'b1, 4'(i),     servo_position(1'b1, 4'(i),     segment_on(mt, i)));
        push_write(1'b1, 4'(i + 8), servo_position(1'b1, 4'(i + 8), segment_on(mu, i)));
      end
    end
    tail      = expected_writes.pop_back();
    tail.last = 1'b1;
    expected_writes.push_back(tail);
    // The digits are remembered in a sleep hour too.
    shown_minute_tens  = mt;
    shown_minute_units = mu;
    shown_hour_tens    = ht;
    shown_hour_units   = hu;
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Compares one accepted write with the oldest prediction, and on the final
  // write of a run the run length with the typed one, where there is one.
  task automatic check_write();
    servo_write_t want;
    int           typed;
    writes_in_run++;
    if (expected_writes.size() == 0) begin
      note_mismatch("unexpected write on channel", -1, servo_wr.channel);
    end else begin
      want = expected_writes.pop_front();
      if (servo_wr.bank !== want.bank) note_mismatch("bank", want.bank, servo_wr.bank);
      if (servo_wr.channel !== want.channel)
        note_mismatch("channel", want.channel, servo_wr.channel);
      if (servo_wr.pulse_off !== want.pulse_off)
        note_mismatch("pulse_off", want.pulse_off, servo_wr.pulse_off);
      if (servo_wr.last !== want.last) note_mismatch("last", want.last, servo_wr.last);
    end
    if (servo_wr.last === 1'b1) begin
      if (run_lengths.size() > 0) begin
        typed = run_lengths.pop_front();
        if ((typed != 0) && (typed != writes_in_run))
          note_mismatch("run length", typed, writes_in_run);
      end
      writes_in_run = 0;
    end
  endtask

  // Values are sampled at the clock edge, before any of this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && servo_wr.valid && servo_wr.ready) begin
      check_write();
    end
  end

  // The receiver drops ready in bursts of random length at the phase's stall rate.
  initial begin
    servo_wr.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        servo_wr.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      servo_wr.ready <= 1'b1;
    end
  end

  // Presents one reading and waits for the request to be taken. Valid stays up
  // afterwards, so back-to-back requests never lower it within a step.
  task automatic send_reading(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s,
                              input int typed_writes);
    time_req.valid   <= 1'b1;
    time_req.hours   <= h;
    time_req.minutes <= m;
    time_req.seconds <= s;
    do @(posedge clk_i); while (time_req.ready !== 1'b1);
    predict_readout(h, m, s);
    run_lengths.push_back(typed_writes);
  endtask

  task automatic maybe_pause_sender();
    if ($urandom_range(0, 99) < gap_pct) begin
      time_req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Holds off new requests until every predicted write has come back, then
  // lets the block settle.
  task automatic wait_until_drained();
    time_req.valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_CLEAR_OFFSET: clear_offset = value;
      CFG_SLEEP_FIRST:  sleep_first  = value[4:0];
      CFG_SLEEP_LAST:   sleep_last   = value[4:0];
      CFG_SV_HOUR:      sv_hour      = value[4:0];
      CFG_SV_FIRST:     sv_first     = value[5:0];
      CFG_SV_LAST:      sv_last      = value[5:0];
      default: ;
    endcase
  endtask

  // The first phases take fixed corner settings; the rest are drawn at random.
  task automatic configure_phase(input int phase);
    int offset, first_h, last_h, view_h, first_m, last_m;
    case (phase)
      0: begin
        // No push-aside offset, no sleep at all, seconds shown all of hour 0.
        offset = 0; first_h = 23; last_h = 0; view_h = 0; first_m = 0; last_m = 59;
      end
      1: begin
        // Widest offset saturates both ways; empty seconds-view span.
        offset = 4095; first_h = 0; last_h = 5; view_h = 12; first_m = 30; last_m = 10;
      end
      2: begin
        // Only the widest hour code sleeps; the view covers out-of-range minutes.
        offset = 500; first_h = 31; last_h = 31; view_h = 31; first_m = 60; last_m = 63;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       offset = 0;
          1:       offset = 4095;
          2:       offset = $urandom_range(0, 4095);
          default: offset = $urandom_range(0, 600);
        endcase
        first_h = $urandom_range(0, 23);
        last_h  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                              : first_h + $urandom_range(0, 6);
        view_h  = $urandom_range(0, 23);
        first_m = $urandom_range(0, 59);
        last_m  = first_m + $urandom_range(0, 4);
      end
    endcase
    write_register(CFG_CLEAR_OFFSET, CFG_DATA_W'(offset));
    write_register(CFG_SLEEP_FIRST,  CFG_DATA_W'(first_h));
    write_register(CFG_SLEEP_LAST,   CFG_DATA_W'(last_h));
    write_register(CFG_SV_HOUR,      CFG_DATA_W'(view_h));
    write_register(CFG_SV_FIRST,     CFG_DATA_W'(first_m));
    write_register(CFG_SV_LAST,      CFG_DATA_W'(last_m));
    cfg_we_i <= 1'b0;
  endtask

  // Draws one random reading. Most follow the wall clock or aim at the seconds
  // view and the sleep edges; the rest are in range or anywhere in the field widths.
  task automatic pick_reading(output logic [4:0] h, output logic [5:0] m, output logic [5:0] s);
    int pick, total;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      total  = wall_s + $urandom_range(1, 150);
      wall_s = total % 60;
      total  = wall_m + total / 60;
      wall_m = total % 60;
      wall_h = (wall_h + total / 60) % 24;
      h = 5'(wall_h);
      m = 6'(wall_m);
      s = 6'(wall_s);
    end else if (pick < 70) begin
      h = sv_hour;
      m = (sv_first <= sv_last) ? 6'($urandom_range(sv_first, sv_last))
                                : 6'($urandom_range(0, 59));
      s = 6'($urandom_range(0, 59));
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0:       h = sleep_first - 5'd1;
        1:       h = sleep_first;
        2:       h = sleep_last;
        default: h = sleep_last + 5'd1;
      endcase
      m = 6'($urandom_range(0, 59));
      s = 6'($urandom_range(0, 59));
    end else if (pick < 92) begin
      h = 5'($urandom_range(0, 23));
      m = 6'($urandom_range(0, 59));
      s = 6'($urandom_range(0, 59));
    end else begin
      h = 5'($urandom_range(0, 31));
      m = 6'($urandom_range(0, 63));
      s = 6'($urandom_range(0, 63));
    end
  endtask

  initial begin
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;

    // Reset state of the shadow model.
    clear_offset       = 12'd100;
    sleep_first        = 5'd7;
    sleep_last         = 5'd18;
    sv_hour            = 5'd23;
    sv_first           = 6'd58;
    sv_last            = 6'd59;
    shown_minute_tens  = 4'd0;
    shown_minute_units = 4'd0;
    shown_hour_tens    = 4'd0;
    shown_hour_units   = 4'd0;
    writes_in_run      = 0;
    mismatches         = 0;
    gap_pct            = 20;
    stall_pct          = 20;
    wall_h             = 0;
    wall_m             = 0;
    wall_s             = 0;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    time_req.valid   = 1'b0;
    time_req.hours   = '0;
    time_req.minutes = '0;
    time_req.seconds = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass at the reset configuration.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_reading(READINGS[i].hours, READINGS[i].minutes, READINGS[i].seconds,
                   int'(READINGS[i].writes));
      maybe_pause_sender();
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_until_drained();
      configure_phase(phase);
      // The last phase runs flat out on both sides; the others pick a rate.
      if (phase == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 20;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then the sender holds back until the block has run dry.
        if ((phase != PHASES - 1) && ($urandom_range(0, 99) < 3)) wait_until_drained();
        pick_reading(h, m, s);
        send_reading(h, m, s, 0);
        maybe_pause_sender();
      end
    end

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if ((mismatches == 0) && (expected_writes.size() == 0) && (run_lengths.size() == 0)) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
